FILE: design/nqueens_solution_enumerator_top_assert.svh
`ifndef NQUEENS_SOLUTION_ENUMERATOR_TOP_ASSERT_SVH
`define NQUEENS_SOLUTION_ENUMERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NQSE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nqse: implication check failed");

// next-cycle implication, checked out of reset
`define NQSE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nqse: next-cycle check failed");

`endif

FILE: design/nqse_pkg.sv
`timescale 1ns / 1ps
package nqse_pkg;

    localparam int MAX_BOARD = 8;
    localparam int ROW_W     = 3;
    localparam int LVL_W     = 4;
    localparam int BS_W      = 4;
    localparam int DIAG_W    = 2 * MAX_BOARD - 1;
    localparam int DIDX_W    = $clog2(DIAG_W);
    localparam int QR_W      = ROW_W * MAX_BOARD;
    localparam int CNT_W     = 12;

    localparam logic [BS_W-1:0]  BS_RESET = BS_W'(8);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic clear;
        logic lift;
        logic step;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic lvl_gt_n;
        logic lvl_eq_n;
        logic finish;
    } dp_stat_t;

endpackage

FILE: design/nqse_ctrl.sv
`timescale 1ns / 1ps
module nqse_ctrl import nqse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_restart,
    output logic     m_valid,
    input  logic     m_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.clear  = s_restart;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (stat.done) begin
                    state_next = ST_LOAD;
                end else if (stat.lvl_gt_n) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RUN;
                end else begin
                    cmd.lift   = stat.lvl_eq_n;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (stat.finish) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/nqse_dp.sv
`timescale 1ns / 1ps
module nqse_dp import nqse_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [BS_W-1:0]  cfg_board_size,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic [QR_W-1:0]  queen_rows,
    output logic             found,
    output logic [CNT_W-1:0] solution_number
);

    logic [BS_W-1:0]      bs_reg;
    logic [ROW_W-1:0]     placed_reg [MAX_BOARD];
    logic [MAX_BOARD-1:0] row_taken_reg;
    logic [DIAG_W-1:0]    rise_reg;
    logic [DIAG_W-1:0]    fall_reg;
    logic [LVL_W-1:0]     level_reg;
    logic [LVL_W-1:0]     try_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [QR_W-1:0]      rows_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     num_reg;

    logic [LVL_W-1:0]     n;
    logic [ROW_W-1:0]     row;
    logic [ROW_W-1:0]     col;
    logic [DIDX_W-1:0]    rise_idx;
    logic [DIDX_W-1:0]    fall_idx;
    logic [MAX_BOARD-1:0] rb;
    logic [DIAG_W-1:0]    db;
    logic [DIAG_W-1:0]    fb;
    logic                 free;
    logic                 try_lt_n;
    logic [LVL_W-1:0]     level_inc;
    logic [LVL_W-1:0]     lcol;
    logic [ROW_W-1:0]     lrow;
    logic [DIDX_W-1:0]    lrise_idx;
    logic [DIDX_W-1:0]    lfall_idx;
    logic                 do_lift;
    logic [QR_W-1:0]      packed_rows;
    logic [CNT_W-1:0]     count_inc;

    // edge in use: zero means one, oversize saturates
    always_comb begin
        if (bs_reg == '0) begin
            n = LVL_W'(1);
        end else if (bs_reg > BS_W'(MAX_BOARD)) begin
            n = LVL_W'(MAX_BOARD);
        end else begin
            n = bs_reg;
        end
    end

    // trial square
    assign row       = try_reg[ROW_W-1:0];
    assign col       = level_reg[ROW_W-1:0];
    assign rise_idx  = DIDX_W'(row) + DIDX_W'(col);
    assign fall_idx  = DIDX_W'(col) + DIDX_W'(MAX_BOARD - 1) - DIDX_W'(row);
    assign rb        = {{(MAX_BOARD-1){1'b0}}, 1'b1} << row;
    assign db        = {{(DIAG_W-1){1'b0}}, 1'b1} << rise_idx;
    assign fb        = {{(DIAG_W-1){1'b0}}, 1'b1} << fall_idx;
    assign free      = ((row_taken_reg & rb) == '0) && ((rise_reg & db) == '0)
                       && ((fall_reg & fb) == '0);
    assign try_lt_n  = try_reg < n;
    assign level_inc = level_reg + LVL_W'(1);

    // queen lifted from the last filled column
    assign lcol      = level_reg - LVL_W'(1);
    assign lrow      = placed_reg[lcol[ROW_W-1:0]];
    assign lrise_idx = DIDX_W'(lrow) + DIDX_W'(lcol[ROW_W-1:0]);
    assign lfall_idx = DIDX_W'(lcol[ROW_W-1:0]) + DIDX_W'(MAX_BOARD - 1) - DIDX_W'(lrow);
    assign do_lift   = cmd.lift || (cmd.step && !try_lt_n && level_reg != '0);

    assign stat.done     = done_reg;
    assign stat.lvl_gt_n = level_reg > n;
    assign stat.lvl_eq_n = level_reg == n;
    assign stat.finish   = try_lt_n ? (free && level_inc == n) : (level_reg == '0);

    always_comb begin
        packed_rows = '0;
        for (int c = 0; c < MAX_BOARD; c++) begin
            if (LVL_W'(c) < n) begin
                packed_rows[ROW_W*c +: ROW_W] = placed_reg[c];
            end
        end
    end

    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg <= BS_RESET;
        end else if (cfg_we) begin
            bs_reg <= cfg_board_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we || cmd.clear) begin
            for (int c = 0; c < MAX_BOARD; c++) begin
                placed_reg[c] <= '0;
            end
            row_taken_reg <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            level_reg     <= '0;
            try_reg       <= '0;
            done_reg      <= 1'b0;
            count_reg     <= '0;
        end else if (do_lift) begin
            row_taken_reg[lrow]  <= 1'b0;
            rise_reg[lrise_idx]  <= 1'b0;
            fall_reg[lfall_idx]  <= 1'b0;
            level_reg            <= lcol;
            try_reg              <= LVL_W'(lrow) + LVL_W'(1);
        end else if (cmd.step) begin
            if (try_lt_n && free) begin
                row_taken_reg   <= row_taken_reg | rb;
                rise_reg        <= rise_reg | db;
                fall_reg        <= fall_reg | fb;
                placed_reg[col] <= row;
                level_reg       <= level_inc;
                try_reg         <= '0;
            end else if (try_lt_n) begin
                try_reg <= try_reg + LVL_W'(1);
            end else begin
                done_reg <= 1'b1;
            end
        end else if (cmd.load && !done_reg) begin
            count_reg <= count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (done_reg) begin
                rows_reg  <= '0;
                found_reg <= 1'b0;
                num_reg   <= count_reg;
            end else begin
                rows_reg  <= packed_rows;
                found_reg <= 1'b1;
                num_reg   <= count_inc;
            end
        end
    end

    assign queen_rows      = rows_reg;
    assign found           = found_reg;
    assign solution_number = num_reg;

endmodule

FILE: design/nqueens_solution_enumerator_top.sv
`timescale 1ns / 1ps
// N-queens solution enumerator.
// Input channel s_*: one beat per request; s_restart = 1 clears the search
// and the solution count, 0 resumes after the last reported solution.
// Result channel m_*: one beat per request with m_queen_rows (3 bits per
// column, column 0 lowest), m_found, and the saturating m_solution_number.
// cfg_*: writes board_size (1..8; 0 acts as 1, above 8 acts as 8) and
// clears the search; taken at any time, meant to be used while idle.
// After a request beat the controller steps through set-up, the search
// loop, load and the result beat; the loop makes one placement trial or
// backtrack per cycle, and the backtrack off the last solution is taken
// in set-up. A request on an exhausted search goes from set-up straight
// to load. One request is in flight at a time; s_ready is low from
// acceptance until the result beat is taken.
// Reset: board_size = 8, search cleared, count zero.
// A stalled receiver holds the result in the output register; no new
// request is taken until that beat goes.
module nqueens_solution_enumerator_top import nqse_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [BS_W-1:0]  cfg_board_size,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_restart,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [QR_W-1:0]  m_queen_rows,
    output logic             m_found,
    output logic [CNT_W-1:0] m_solution_number
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    nqse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    nqse_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_board_size  (cfg_board_size),
        .cmd             (cmd),
        .stat            (stat),
        .queen_rows      (m_queen_rows),
        .found           (m_found),
        .solution_number (m_solution_number)
    );

`include "nqueens_solution_enumerator_top_assert.svh"

    `NQSE_ASSERT_IMP(a_one_in_flight, aclk, aresetn, m_valid, !s_ready)
    `NQSE_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_valid && s_ready, !s_ready)
    `NQSE_ASSERT_IMP(a_exhausted_empty, aclk, aresetn, m_valid && !m_found,
        m_queen_rows == '0)
    `NQSE_ASSERT_IMP(a_found_counted, aclk, aresetn, m_valid && m_found,
        m_solution_number != '0)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import nqse_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int IDLE_PCT       = 18;
    localparam int CALM_FROM      = 700;
    localparam int CALM_TO        = 1000;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 500;
    localparam int N_PLAN         = 24;
    localparam int N_PHASES       = 13;

    typedef struct packed {
        logic [QR_W-1:0]  rows;
        logic             found;
        logic [CNT_W-1:0] num;
    } answer_t;

    typedef struct packed {
        logic             wr;
        logic [BS_W-1:0]  bs;
        logic             rst;
        logic             chk;
        logic [QR_W-1:0]  rows;
        logic             found;
        logic [CNT_W-1:0] num;
    } plan_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [BS_W-1:0]  cfg_board_size = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_restart = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [QR_W-1:0]  m_queen_rows;
    logic             m_found;
    logic [CNT_W-1:0] m_solution_number;

    nqueens_solution_enumerator_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_board_size    (cfg_board_size),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_restart         (s_restart),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_queen_rows      (m_queen_rows),
        .m_found           (m_found),
        .m_solution_number (m_solution_number)
    );

    always #6 aclk = ~aclk;

    // search state mirror
    logic [BS_W-1:0]   board_reg;
    logic [ROW_W-1:0]  queen_at [MAX_BOARD];
    logic [MAX_BOARD-1:0] rows_used;
    logic [DIAG_W-1:0] rise_used;
    logic [DIAG_W-1:0] fall_used;
    int                depth;
    int                try_row;
    bit                exhausted;
    int                sol_count;

    answer_t pending_answers [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      answers_seen = 0;
    int      hold_left = 0;
    bit      held_once = 1'b0;
    int      quiet_cycles = 0;

    task automatic clear_search();
        for (int c = 0; c < MAX_BOARD; c++) queen_at[c] = '0;
        rows_used = '0;
        rise_used = '0;
        fall_used = '0;
        depth     = 0;
        try_row   = 0;
        exhausted = 1'b0;
        sol_count = 0;
    endtask

    task automatic lift_queen();
        int c;
        int r;
        c = depth - 1;
        r = queen_at[c];
        rows_used[r] = 1'b0;
        rise_used[r + c] = 1'b0;
        fall_used[c + MAX_BOARD - 1 - r] = 1'b0;
        depth   = c;
        try_row = r + 1;
    endtask

    task automatic advance_search(input bit rst, output answer_t ans);
        int  n;
        int  r;
        int  c;
        bit  going;
        n = (board_reg == 0) ? 1 : ((board_reg > MAX_BOARD) ? MAX_BOARD : int'(board_reg));
        if (rst) clear_search();
        if (!exhausted) begin
            if (depth > n) clear_search();
            if (depth == n) lift_queen();
            going = 1'b1;
            while (going) begin
                if (try_row < n) begin
                    r = try_row;
                    c = depth;
                    if (!rows_used[r] && !rise_used[r + c] &&
                        !fall_used[c + MAX_BOARD - 1 - r]) begin
                        rows_used[r] = 1'b1;
                        rise_used[r + c] = 1'b1;
                        fall_used[c + MAX_BOARD - 1 - r] = 1'b1;
                        queen_at[c] = r[ROW_W-1:0];
                        depth   = c + 1;
                        try_row = 0;
                        if (depth == n) going = 1'b0;
                    end else begin
                        try_row = r + 1;
                    end
                end else if (depth == 0) begin
                    exhausted = 1'b1;
                    going = 1'b0;
                end else begin
                    lift_queen();
                end
            end
        end
        ans = '0;
        if (exhausted) begin
            ans.num = sol_count[CNT_W-1:0];
        end else begin
            if (sol_count < int'(CNT_MAX)) sol_count++;
            for (int k = 0; k < n; k++) ans.rows[ROW_W*k +: ROW_W] = queen_at[k];
            ans.found = 1'b1;
            ans.num   = sol_count[CNT_W-1:0];
        end
    endtask

    task automatic offer_request(input bit rst, input bit typed, input answer_t typed_ans);
        answer_t ans;
        while ($urandom_range(99) < ((items_sent >= CALM_FROM && items_sent < CALM_TO) ?
                                     0 : IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_search(rst, ans);
        pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
        items_sent++;
    endtask

    task automatic write_board(input logic [BS_W-1:0] bs);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_board_size <= bs;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board_reg = bs;
        clear_search();
        cfg_valid <= 1'b0;
    endtask

    // result beats
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: rows %h found %b num %0d",
                                 m_queen_rows, m_found, m_solution_number);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_queen_rows !== want.rows || m_found !== want.found ||
                        m_solution_number !== want.num) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h %b %0d, got %h %b %0d",
                                     want.rows, want.found, want.num,
                                     m_queen_rows, m_found, m_solution_number);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && answers_seen >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (answers_seen >= CALM_FROM && answers_seen < CALM_TO) ||
                           ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        plan_row_t plan [N_PLAN];
        int        sizes [N_PHASES];
        int        count;
        answer_t   typed_ans;

        plan = '{
            '{1'b0, 4'd8,  1'b1, 1'b1, 24'h672BE0, 1'b1, 12'd1},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b1, 4'd1,  1'b0, 1'b1, 24'h0,      1'b1, 12'd1},
            '{1'b0, 4'd0,  1'b0, 1'b1, 24'h0,      1'b0, 12'd1},
            '{1'b0, 4'd0,  1'b0, 1'b1, 24'h0,      1'b0, 12'd1},
            '{1'b0, 4'd0,  1'b1, 1'b1, 24'h0,      1'b1, 12'd1},
            '{1'b1, 4'd0,  1'b0, 1'b1, 24'h0,      1'b1, 12'd1},
            '{1'b1, 4'd2,  1'b1, 1'b1, 24'h0,      1'b0, 12'd0},
            '{1'b1, 4'd3,  1'b0, 1'b1, 24'h0,      1'b0, 12'd0},
            '{1'b1, 4'd4,  1'b1, 1'b1, 24'h000419, 1'b1, 12'd1},
            '{1'b0, 4'd0,  1'b0, 1'b1, 24'h0002C2, 1'b1, 12'd2},
            '{1'b0, 4'd0,  1'b0, 1'b1, 24'h0,      1'b0, 12'd2},
            '{1'b0, 4'd0,  1'b0, 1'b1, 24'h0,      1'b0, 12'd2},
            '{1'b0, 4'd0,  1'b1, 1'b1, 24'h000419, 1'b1, 12'd1},
            '{1'b1, 4'd15, 1'b0, 1'b1, 24'h672BE0, 1'b1, 12'd1},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b1, 4'd9,  1'b1, 1'b1, 24'h672BE0, 1'b1, 12'd1},
            '{1'b1, 4'd5,  1'b1, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b1, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0},
            '{1'b0, 4'd0,  1'b0, 1'b0, 24'h0,      1'b0, 12'd0}
        };
        sizes = '{5, 8, 1, 6, 0, 7, 15, 4, 2, 9, 3, 6, 5};

        board_reg = BS_RESET;
        clear_search();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_PLAN; i++) begin
            if (plan[i].wr) write_board(plan[i].bs);
            typed_ans.rows  = plan[i].rows;
            typed_ans.found = plan[i].found;
            typed_ans.num   = plan[i].num;
            offer_request(plan[i].rst, plan[i].chk, typed_ans);
        end

        // big boards are slow per beat, so they get short phases
        for (int p = 0; p < N_PHASES; p++) begin
            write_board(sizes[p][BS_W-1:0]);
            count = (sizes[p] >= 7) ? 60 : 180;
            for (int j = 0; j < count; j++)
                offer_request($urandom_range(19) == 0, 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/nqse_pkg.sv
design/nqse_ctrl.sv
design/nqse_dp.sv
design/nqueens_solution_enumerator_top.sv
tb/testbench.sv
